@@ rtl/core/ssd_pkg.sv @@
package ssd_pkg;

    // Motor slots and index widths
    localparam int MOTOR_COUNT   = 8;
    localparam int MOTOR_W       = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int MOTOR_FIELD_W = 3;
    localparam int MASK_W        = 8;

    // Field widths
    localparam int POS_W    = 32;
    localparam int OVS_W    = 16;
    localparam int AMP_W    = 15;
    localparam int SWING_W  = 16;
    localparam int CYC_W    = 8;
    localparam int PHASE_W  = 3;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Divider sizing: amplitude times cycles over cycles
    localparam int DIVIDEND_W = AMP_W + CYC_W;
    localparam int DIVISOR_W  = CYC_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
    localparam logic [AMP_W-1:0] AMP_MAX = '1;

    // Stream widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OVERSHOOT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AMP    = 2'd3;

    // Input operation codes
    localparam logic OP_START    = 1'b0;
    localparam logic OP_LEG_DONE = 1'b1;

    typedef enum logic [PHASE_W-1:0] {
        PH_NONE      = 3'd0,
        PH_PRIMARY   = 3'd1,
        PH_OVERSHOOT = 3'd2,
        PH_APPROACH  = 3'd3,
        PH_DPOS      = 3'd4,
        PH_DNEG      = 3'd5,
        PH_RETURN    = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_WALK,
        ST_READ,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [OVS_W-1:0] overshoot;
        logic [AMP_W-1:0] amplitude;
        logic [CYC_W-1:0] cycles;
        logic [AMP_W-1:0] min_amp;
    } t_cfg;

    typedef struct packed {
        logic               op;
        logic [MASK_W-1:0]  mask;
        logic [MOTOR_FIELD_W-1:0] index;
        logic [POS_W-1:0]   target;
    } t_item;

    typedef struct packed {
        logic               accepted;
        logic               cmd_valid;
        logic [MOTOR_FIELD_W-1:0] motor;
        logic [POS_W-1:0]   target;
        logic [PHASE_W-1:0] phase;
        logic               last;
    } t_result;

    // One motor entry of the state memory
    typedef struct packed {
        t_phase             phase;
        logic [POS_W-1:0]   center;
        logic [CYC_W-1:0]   cycles;
        logic [SWING_W-1:0] swing;
    } t_entry;

    typedef struct packed {
        logic               rd_en;
        logic [MOTOR_W-1:0] rd_addr;
        logic               wr_en;
        logic [MOTOR_W-1:0] wr_addr;
        t_entry             wr_data;
    } t_mem_req;

endpackage

@@ rtl/core/stepper_settle_dither_sequencer_unit.sv @@
// Settle sequencer for up to eight stepper motors. A start item (tuser 0)
// names motors by mask and an absolute target; it is rejected with a single
// result if any named motor still has a leg running, otherwise it returns one
// move command per named motor, in motor order, with tlast on the final one.
// A leg-done item (tuser 1) advances that motor through overshoot, approach,
// decaying dither swings and a final return, and always returns one result.
// Items are taken one at a time. A start walks the motor slots in order up to
// the highest named motor; a start with an empty mask instead returns a single
// accepted result with no command. A leg-done reads the motor's entry and, when
// a new swing amplitude is needed, waits on the bit-serial divider that forms
// amplitude times cycles left over total cycles. Per-motor state lives in a
// synchronous memory with a registered read port. A result waiting on
// the output does not hold off the next input transfer, but the item then
// waits until that result is taken. The configuration registers are live and
// should be written only while no item is in progress.
module stepper_settle_dither_sequencer_unit
    import ssd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata: motor_mask[7:0], motor_index[10:8], target_position[42:11]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: op
    input  logic                  i_s_axis_tuser,
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: command_motor[2:0], command_target[34:3], new_phase[37:35]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // tuser: accepted[0], command_valid[1]
    output logic [OUT_USER_W-1:0] o_m_axis_tuser,
    // tlast: last_result
    output logic                  o_m_axis_tlast
);

    t_cfg     r_cfg;
    t_item    item;
    t_result  result;
    t_mem_req mem_req;
    t_entry   rd_data;
    logic     div_start;
    logic     div_done;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [DIVIDEND_W-1:0] div_quotient;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                CFG_OVERSHOOT: r_cfg.overshoot <= i_cfg_data;
                CFG_AMPLITUDE: r_cfg.amplitude <= i_cfg_data[AMP_W-1:0];
                CFG_CYCLES:    r_cfg.cycles    <= i_cfg_data[CYC_W-1:0];
                CFG_MIN_AMP:   r_cfg.min_amp   <= i_cfg_data[AMP_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Unpack the input item
    assign item.op     = i_s_axis_tuser;
    assign item.mask   = i_s_axis_tdata[7:0];
    assign item.index  = i_s_axis_tdata[10:8];
    assign item.target = i_s_axis_tdata[42:11];

    // Pack the result item
    assign o_m_axis_tdata = {2'b00, result.phase, result.target, result.motor};
    assign o_m_axis_tuser = {result.cmd_valid, result.accepted};
    assign o_m_axis_tlast = result.last;

    ssd_sequencer u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_s_valid      (i_s_axis_tvalid),
        .o_s_ready      (o_s_axis_tready),
        .i_item         (item),
        .o_m_valid      (o_m_axis_tvalid),
        .i_m_ready      (i_m_axis_tready),
        .o_result       (result),
        .o_mem_req      (mem_req),
        .i_rd_data      (rd_data),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .o_div_divisor  (div_divisor),
        .i_div_done     (div_done),
        .i_div_quotient (div_quotient)
    );

    ssd_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    ssd_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

endmodule

@@ rtl/core/ssd_state_mem.sv @@
module ssd_state_mem
    import ssd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    t_entry                 r_mem [MOTOR_COUNT];
    logic [MOTOR_COUNT-1:0] r_valid;
    t_entry                 r_rd_data;
    logic                   r_rd_valid;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Entry valid bits: a never-written entry reads as phase none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data  <= r_mem[i_req.rd_addr];
            r_rd_valid <= r_valid[i_req.rd_addr];
        end
    end

    always_comb begin
        o_rd_data = r_rd_data;
        if (!r_rd_valid) begin
            o_rd_data.phase  = PH_NONE;
            o_rd_data.cycles = '0;
            o_rd_data.swing  = '0;
        end
    end

endmodule

@@ rtl/core/ssd_divider.sv @@
module ssd_divider
    import ssd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;
    logic [DIVISOR_W:0]    diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[DIVIDEND_W-1]};
        fits  = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath of the quotient register, shared with the dividend, and the remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
            r_rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/core/ssd_sequencer.sv @@
module ssd_sequencer
    import ssd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_s_valid,
    output logic     o_s_ready,
    input  t_item    i_item,
    output logic     o_m_valid,
    input  logic     i_m_ready,
    output t_result  o_result,
    output t_mem_req o_mem_req,
    input  t_entry   i_rd_data,
    output logic     o_div_start,
    output logic [DIVIDEND_W-1:0] o_div_dividend,
    output logic [DIVISOR_W-1:0]  o_div_divisor,
    input  logic     i_div_done,
    input  logic [DIVIDEND_W-1:0] i_div_quotient
);

    t_state                 r_state, n_state;
    logic [MOTOR_COUNT-1:0] r_mask, n_mask;
    logic [MOTOR_W-1:0]     r_idx, n_idx;
    logic [POS_W-1:0]       r_target, n_target;
    logic [MOTOR_COUNT-1:0] r_running, n_running;
    logic [AMP_W-1:0]       r_amp, n_amp;
    logic                   r_swing_ok, n_swing_ok;
    t_result                r_single, n_single;
    logic                   r_out_valid, n_out_valid;
    t_result                r_out, n_out;

    logic                   out_free;
    logic [MOTOR_COUNT-1:0] in_mask;
    logic                   idx_bad;
    logic [MOTOR_COUNT-1:0] walk_rest;
    t_phase                 start_phase;
    logic [POS_W-1:0]       start_aim;
    logic                   try_swing;
    logic [AMP_W-1:0]       q_sat;
    t_phase                 emit_phase;
    logic                   emit_cmd;
    logic [POS_W-1:0]       emit_aim;
    t_entry                 emit_entry;

    assign out_free  = !r_out_valid || i_m_ready;
    assign in_mask   = i_item.mask[MOTOR_COUNT-1:0];
    assign idx_bad   = (32'(i_item.index) >= MOTOR_COUNT);
    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_out_valid;
    assign o_result  = r_out;

    // Remaining mask once the current motor is served
    always_comb begin
        walk_rest        = r_mask;
        walk_rest[r_idx] = 1'b0;
    end

    // First leg of a start
    always_comb begin
        if (i_cfg.overshoot != '0) begin
            start_phase = PH_OVERSHOOT;
        end else if (i_cfg.amplitude != '0) begin
            start_phase = PH_PRIMARY;
        end else begin
            start_phase = PH_NONE;
        end
        start_aim = (start_phase == PH_OVERSHOOT) ?
                    r_target - {{(POS_W-OVS_W){i_cfg.overshoot[OVS_W-1]}}, i_cfg.overshoot} :
                    r_target;
    end

    // Decide whether the leg end needs a new swing amplitude
    always_comb begin
        try_swing = (((i_rd_data.phase == PH_PRIMARY) || (i_rd_data.phase == PH_APPROACH))
                     && (i_cfg.amplitude != '0)) || (i_rd_data.phase == PH_DNEG);
        try_swing = try_swing && (i_rd_data.cycles != '0) && (i_cfg.cycles != '0);
        o_div_dividend = DIVIDEND_W'(i_cfg.amplitude) * DIVIDEND_W'(i_rd_data.cycles);
        o_div_divisor  = i_cfg.cycles;
        q_sat = (i_div_quotient > DIVIDEND_W'(AMP_MAX)) ? AMP_MAX : i_div_quotient[AMP_W-1:0];
    end

    // Phase advance on a leg end
    always_comb begin
        emit_entry = i_rd_data;
        emit_phase = PH_NONE;
        emit_cmd   = 1'b0;
        emit_aim   = '0;
        case (i_rd_data.phase)
            PH_PRIMARY, PH_APPROACH: begin
                if (r_swing_ok) begin
                    emit_entry.swing  = SWING_W'(r_amp);
                    emit_entry.cycles = i_rd_data.cycles - 1'b1;
                    emit_aim   = i_rd_data.center + POS_W'(r_amp);
                    emit_phase = PH_DPOS;
                    emit_cmd   = 1'b1;
                end
            end
            PH_OVERSHOOT: begin
                emit_aim   = i_rd_data.center;
                emit_phase = PH_APPROACH;
                emit_cmd   = 1'b1;
            end
            PH_DPOS: begin
                emit_aim   = i_rd_data.center - POS_W'(i_rd_data.swing);
                emit_phase = PH_DNEG;
                emit_cmd   = 1'b1;
            end
            PH_DNEG: begin
                emit_cmd = 1'b1;
                if (r_swing_ok) begin
                    emit_entry.swing  = SWING_W'(r_amp);
                    emit_entry.cycles = i_rd_data.cycles - 1'b1;
                    emit_aim   = i_rd_data.center + POS_W'(r_amp);
                    emit_phase = PH_DPOS;
                end else begin
                    emit_aim   = i_rd_data.center;
                    emit_phase = PH_RETURN;
                end
            end
            default: begin
                emit_phase = PH_NONE;
            end
        endcase
        emit_entry.phase = emit_phase;
    end

    // Next state and control
    always_comb begin
        n_state     = r_state;
        n_mask      = r_mask;
        n_idx       = r_idx;
        n_target    = r_target;
        n_running   = r_running;
        n_amp       = r_amp;
        n_swing_ok  = r_swing_ok;
        n_single    = r_single;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_mem_req   = '0;
        o_div_start = 1'b0;

        // drop the result once its transfer completes
        if (r_out_valid && i_m_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    n_target      = i_item.target;
                    n_mask        = in_mask;
                    n_idx         = '0;
                    n_single      = '0;
                    n_single.last = 1'b1;
                    if (i_item.op == OP_START) begin
                        if ((in_mask & r_running) != '0) begin
                            n_state = ST_SINGLE;
                        end else if (in_mask == '0) begin
                            n_single.accepted = 1'b1;
                            n_state = ST_SINGLE;
                        end else begin
                            n_state = ST_WALK;
                        end
                    end else if (idx_bad) begin
                        n_state = ST_SINGLE;
                    end else begin
                        n_idx             = i_item.index[MOTOR_W-1:0];
                        o_mem_req.rd_en   = 1'b1;
                        o_mem_req.rd_addr = i_item.index[MOTOR_W-1:0];
                        n_state           = ST_READ;
                    end
                end
            end
            ST_SINGLE: begin
                if (out_free) begin
                    n_out       = r_single;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_WALK: begin
                // step over unselected motors, serve selected ones in order
                if (!r_mask[r_idx]) begin
                    n_idx = r_idx + 1'b1;
                end else if (out_free) begin
                    o_mem_req.wr_en          = 1'b1;
                    o_mem_req.wr_addr        = r_idx;
                    o_mem_req.wr_data.phase  = start_phase;
                    o_mem_req.wr_data.center = r_target;
                    o_mem_req.wr_data.cycles = i_cfg.cycles;
                    o_mem_req.wr_data.swing  = SWING_W'(i_cfg.amplitude);
                    n_running[r_idx]  = 1'b1;
                    n_mask            = walk_rest;
                    n_out.accepted    = 1'b1;
                    n_out.cmd_valid   = 1'b1;
                    n_out.motor       = MOTOR_FIELD_W'(r_idx);
                    n_out.target      = start_aim;
                    n_out.phase       = start_phase;
                    n_out.last        = (walk_rest == '0);
                    n_out_valid       = 1'b1;
                    if (walk_rest == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_READ: begin
                if (try_swing) begin
                    o_div_start = 1'b1;
                    n_state     = ST_DIV;
                end else begin
                    n_swing_ok = 1'b0;
                    n_state    = ST_EMIT;
                end
            end
            ST_DIV: begin
                if (i_div_done) begin
                    n_amp      = q_sat;
                    n_swing_ok = (q_sat >= i_cfg.min_amp);
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_mem_req.wr_en   = 1'b1;
                    o_mem_req.wr_addr = r_idx;
                    o_mem_req.wr_data = emit_entry;
                    n_running[r_idx]  = emit_cmd;
                    n_out             = '0;
                    n_out.cmd_valid   = emit_cmd;
                    n_out.phase       = emit_phase;
                    n_out.last        = 1'b1;
                    if (emit_cmd) begin
                        n_out.motor  = MOTOR_FIELD_W'(r_idx);
                        n_out.target = emit_aim;
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_running   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_mask     <= n_mask;
        r_idx      <= n_idx;
        r_target   <= n_target;
        r_amp      <= n_amp;
        r_swing_ok <= n_swing_ok;
        r_single   <= n_single;
        r_out      <= n_out;
    end

endmodule

@@ rtl/core/ssd_checker.sv @@
module ssd_checker
    import ssd_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [OUT_USER_W-1:0] o_m_axis_tuser,
    input logic                  o_m_axis_tlast
);

    // No result is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Items are taken one at a time: ready drops after an input transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready held after a transfer");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // A result without a command carries no motor and no target
    a_no_cmd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[1] |-> o_m_axis_tdata[34:0] == 35'd0)
        else $error("non-command result with motor or target");

    // A result without a command is always the only result of its item
    a_no_cmd_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[1] |-> o_m_axis_tlast)
        else $error("non-command result not marked last");

endmodule

bind stepper_settle_dither_sequencer_unit ssd_checker u_ssd_checker (.*);
